>>> hw/rtl/self_organizing_list_access_defines.svh
// Assertion macros shared by the self-organizing list RTL.
`ifndef SELF_ORGANIZING_LIST_ACCESS_DEFINES_SVH
`define SELF_ORGANIZING_LIST_ACCESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sol_pkg.sv
// Shared constants, types and helper functions of the self-organizing list.
`timescale 1ns / 1ps

package sol_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int COST_W   = 8;
    localparam int STRAT_W  = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Reorder strategy register codes
    typedef enum logic [STRAT_W-1:0] {
        STRAT_NONE          = 2'd0,
        STRAT_MOVE_TO_FRONT = 2'd1,
        STRAT_TRANSPOSE     = 2'd2,
        STRAT_COUNT         = 2'd3
    } t_strategy;

    // What the cell row does when the request is applied
    typedef enum logic [2:0] {
        MODE_HOLD   = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_FRONT  = 3'd2,
        MODE_SWAP   = 3'd3,
        MODE_RANK   = 3'd4
    } t_mode;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               cmp_en;
        logic               move_en;
        t_mode              mode;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   tgt;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] cnt;
    } t_cell_ctl;

    // Suffix OR: bit i is set when any bit at i or above is set (log-depth)
    function automatic logic [CAPACITY-1:0] suffix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] acc;
        acc = v;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            acc = acc | (acc >> s);
        end
        return acc;
    endfunction

    // Index of the set bit of a one-hot (or zero) vector
    function automatic logic [IDX_W-1:0] onehot_idx(input logic [CAPACITY-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (v[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> hw/rtl/sol_cell.sv
// One list slot: holds a key and its counter, compares and shifts with its neighbors.
`timescale 1ns / 1ps

module sol_cell (
    input  logic                         i_clk,
    input  logic [sol_pkg::IDX_W-1:0]    i_index,
    input  sol_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_hi_ge,
    input  logic [sol_pkg::KEY_W-1:0]    i_prev_key,
    input  logic [sol_pkg::COUNT_W-1:0]  i_prev_cnt,
    input  logic [sol_pkg::KEY_W-1:0]    i_next_key,
    input  logic [sol_pkg::COUNT_W-1:0]  i_next_cnt,
    input  logic                         i_ge_prev,
    input  logic                         i_sufx_here,
    input  logic                         i_sufx_next,
    output logic                         o_match,
    output logic                         o_ge,
    output logic [sol_pkg::KEY_W-1:0]    o_key,
    output logic [sol_pkg::COUNT_W-1:0]  o_cnt
);
    import sol_pkg::*;

    logic [KEY_W-1:0]   r_key;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_match;
    logic [KEY_W-1:0]   n_key;
    logic [COUNT_W-1:0] n_cnt;
    logic               active;
    logic               load;
    logic               take_prev;
    logic               take_next;

    // Slot holds a live entry
    assign active = LEN_W'(i_index) < i_ctl.len;

    // Entry ranks at or above the promoted counter (the hit entry itself excluded)
    assign o_ge    = active && !r_match && (r_cnt >= i_ctl.cnt);
    assign o_match = r_match;
    assign o_key   = r_key;
    assign o_cnt   = r_cnt;

    // Decide where this slot takes its next contents from
    always_comb begin
        load      = 1'b0;
        take_prev = 1'b0;
        take_next = 1'b0;
        case (i_ctl.mode)
            MODE_APPEND: begin
                load = (LEN_W'(i_index) == i_ctl.len);
            end
            MODE_FRONT, MODE_SWAP: begin
                load      = (i_index == i_ctl.tgt);
                take_prev = (i_index > i_ctl.tgt) && (i_index <= i_ctl.pos);
            end
            MODE_RANK: begin
                if (i_hi_ge) begin
                    // entry moves back: close the gap, drop it after the last ranking entry
                    if (i_index >= i_ctl.pos) begin
                        if (i_sufx_next) begin
                            take_next = 1'b1;
                        end else if (o_ge && (i_index > i_ctl.pos)) begin
                            load = 1'b1;
                        end
                    end
                end else begin
                    // entry moves forward: open a gap just after the last ranking entry
                    if ((i_index <= i_ctl.pos) && !i_sufx_here) begin
                        if (i_ge_prev) begin
                            load = 1'b1;
                        end else begin
                            take_prev = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Select next slot contents
    always_comb begin
        n_key = r_key;
        n_cnt = r_cnt;
        if (i_ctl.move_en) begin
            if (load) begin
                n_key = i_ctl.key;
                n_cnt = i_ctl.cnt;
            end else if (take_prev) begin
                n_key = i_prev_key;
                n_cnt = i_prev_cnt;
            end else if (take_next) begin
                n_key = i_next_key;
                n_cnt = i_next_cnt;
            end
        end
    end

    // Hold contents; capture compare result in the search cycle
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cnt <= n_cnt;
        if (i_ctl.cmp_en) begin
            r_match <= active && (r_key == i_ctl.key);
        end
    end

endmodule

>>> hw/rtl/self_organizing_list_access.sv
// The result is registered when the reorder step retires. The cell row compares in ST_CMP,
// the sequencer encodes the hit slot and next counter in ST_SEL, and the row shifts in
// ST_MOVE, where the next request may already be accepted; ST_MOVE holds while the
// output slot is still occupied.
// Reset (synchronous, active low) empties the list and sets the strategy to none;
// slot contents need no clearing and there is no clearing pass.
`timescale 1ns / 1ps
`include "self_organizing_list_access_defines.svh"

module self_organizing_list_access (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sol_pkg::STRAT_W-1:0]     i_cfg_strategy,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [15:0]                     i_key,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sol_pkg::COST_W-1:0]      o_cost,
    output logic                            o_hit,
    output logic                            o_dropped
);
    import sol_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_SEL  = 4'b0100,
        ST_MOVE = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_strategy          r_strategy;
    logic [LEN_W-1:0]   r_len;
    logic [KEY_W-1:0]   r_key;
    logic [IDX_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_tgt;
    t_mode              r_mode;
    logic [COUNT_W-1:0] r_item_cnt;
    logic [COST_W-1:0]  r_cost;
    logic               r_hit;
    logic               r_drop;
    logic               r_out_valid;
    logic [COST_W-1:0]  r_out_cost;
    logic               r_out_hit;
    logic               r_out_drop;

    logic               in_fire;
    logic               slot_free;
    logic               move_fire;
    logic               full;
    logic               hi_ge;
    t_cell_ctl          ctl;

    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] ge_vec;
    logic [CAPACITY-1:0] sufx_vec;
    logic [KEY_W-1:0]    cell_key [CAPACITY];
    logic [COUNT_W-1:0]  cell_cnt [CAPACITY];

    logic [IDX_W-1:0]    sel_pos;
    logic                sel_hit;
    logic [COUNT_W-1:0]  sel_cnt;
    logic [COUNT_W-1:0]  sel_inc;
    logic [LEN_W-1:0]    sel_cost;
    t_mode               sel_mode;
    logic [IDX_W-1:0]    sel_tgt;
    logic [COUNT_W-1:0]  sel_item_cnt;

    // Handshakes
    assign slot_free   = !r_out_valid || i_out_ready;
    assign move_fire   = (r_state == ST_MOVE) && slot_free;
    assign o_in_ready  = (r_state == ST_IDLE) || move_fire;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign full        = (r_len == LEN_W'(CAPACITY));

    // Broadcast control to the cell row
    always_comb begin
        ctl.cmp_en  = (r_state == ST_CMP);
        ctl.move_en = move_fire;
        ctl.mode    = r_mode;
        ctl.key     = r_key;
        ctl.pos     = r_pos;
        ctl.tgt     = r_tgt;
        ctl.len     = r_len;
        ctl.cnt     = r_item_cnt;
    end

    // Ranking entries at or after each slot; any of them behind the hit slot
    assign sufx_vec = suffix_or(ge_vec);
    assign hi_ge    = |(sufx_vec & (match_vec << 1));

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0]   prev_key;
        logic [COUNT_W-1:0] prev_cnt;
        logic [KEY_W-1:0]   next_key;
        logic [COUNT_W-1:0] next_cnt;
        logic               ge_prev;
        logic               sufx_next;

        if (g == 0) begin : g_head
            assign prev_key = '0;
            assign prev_cnt = '0;
            assign ge_prev  = 1'b1;
        end else begin : g_body
            assign prev_key = cell_key[g-1];
            assign prev_cnt = cell_cnt[g-1];
            assign ge_prev  = ge_vec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_key  = '0;
            assign next_cnt  = '0;
            assign sufx_next = 1'b0;
        end else begin : g_link
            assign next_key  = cell_key[g+1];
            assign next_cnt  = cell_cnt[g+1];
            assign sufx_next = sufx_vec[g+1];
        end

        sol_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(g)),
            .i_ctl       (ctl),
            .i_hi_ge     (hi_ge),
            .i_prev_key  (prev_key),
            .i_prev_cnt  (prev_cnt),
            .i_next_key  (next_key),
            .i_next_cnt  (next_cnt),
            .i_ge_prev   (ge_prev),
            .i_sufx_here (sufx_vec[g]),
            .i_sufx_next (sufx_next),
            .o_match     (match_vec[g]),
            .o_ge        (ge_vec[g]),
            .o_key       (cell_key[g]),
            .o_cnt       (cell_cnt[g])
        );
    end

    // Pick the hit slot's counter
    always_comb begin
        sel_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_cnt = sel_cnt | (cell_cnt[i] & {COUNT_W{match_vec[i]}});
        end
    end

    // Encode the hit and plan the reorder
    always_comb begin
        sel_pos  = onehot_idx(match_vec);
        sel_hit  = |match_vec;
        sel_inc  = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + COUNT_W'(1);
        sel_cost = sel_hit ? (LEN_W'(sel_pos) + LEN_W'(1)) : r_len;
        sel_tgt  = '0;
        sel_item_cnt = sel_cnt;
        if (sel_hit) begin
            case (r_strategy)
                STRAT_MOVE_TO_FRONT: sel_mode = MODE_FRONT;
                STRAT_TRANSPOSE: begin
                    sel_mode = MODE_SWAP;
                    sel_tgt  = (sel_pos == '0) ? '0 : sel_pos - IDX_W'(1);
                end
                STRAT_COUNT: begin
                    sel_mode     = MODE_RANK;
                    sel_item_cnt = sel_inc;
                end
                default: sel_mode = MODE_HOLD;
            endcase
        end else begin
            sel_mode     = full ? MODE_HOLD : MODE_APPEND;
            sel_item_cnt = '0;
        end
    end

    // Advance the sequencer
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = in_fire ? ST_CMP : ST_IDLE;
            ST_CMP:  n_state = ST_SEL;
            ST_SEL:  n_state = ST_MOVE;
            ST_MOVE: begin
                if (slot_free) begin
                    n_state = in_fire ? ST_CMP : ST_IDLE;
                end else begin
                    n_state = ST_MOVE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_strategy  <= STRAT_NONE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_strategy <= t_strategy'(i_cfg_strategy);
            end
            if (move_fire && (r_mode == MODE_APPEND)) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (move_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and plan payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key <= i_key[KEY_W-1:0];
        end
        if (r_state == ST_SEL) begin
            r_pos      <= sel_pos;
            r_tgt      <= sel_tgt;
            r_mode     <= sel_mode;
            r_item_cnt <= sel_item_cnt;
            r_cost     <= COST_W'(sel_cost);
            r_hit      <= sel_hit;
            r_drop     <= !sel_hit && full;
        end
        if (move_fire) begin
            r_out_cost <= r_cost;
            r_out_hit  <= r_hit;
            r_out_drop <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cost      = r_out_cost;
    assign o_hit       = r_out_hit;
    assign o_dropped   = r_out_drop;

    `SOL_ASSERT_IMPL(a_single_match, i_clk, i_rst_n, r_state == ST_SEL, $onehot0(match_vec), "more than one slot matched the key")
    `SOL_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(CAPACITY), "list length beyond capacity")
    `SOL_ASSERT_IMPL(a_drop_when_full, i_clk, i_rst_n, o_out_valid && o_dropped, !o_hit && full, "drop reported without a full list")
    `SOL_ASSERT_NEXT(a_move_retires, i_clk, i_rst_n, move_fire, o_out_valid && (r_state == ST_IDLE || r_state == ST_CMP), "reorder step did not retire")
    `SOL_ASSERT_IMPL(a_hit_cost, i_clk, i_rst_n, o_out_valid && o_hit, o_cost != '0, "hit reported at position zero")

endmodule
